[rtl/core/dedup_registry_with_tombstones_unit_assert.svh]
// assertion macros for the dedup registry
`ifndef DEDUP_REGISTRY_WITH_TOMBSTONES_UNIT_ASSERT_SVH
`define DEDUP_REGISTRY_WITH_TOMBSTONES_UNIT_ASSERT_SVH

// clocked assertion, off while reset is held
`define DRT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("drt assertion failed");

// clocked assertion, checked during reset too
`define DRT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("drt assertion failed");

`endif

[rtl/core/drt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package drt_pkg;
    localparam int LIVE_SLOTS = 16;
    localparam int TOMB_SLOTS = 64;
    localparam int LIVE_IW    = $clog2(LIVE_SLOTS);
    localparam int TOMB_IW    = $clog2(TOMB_SLOTS);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DUP      = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOT_LIVE = 2'd3;

    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_RETIRE   = 1'b1;

    localparam logic [1:0] CFG_TTL        = 2'd0;
    localparam logic [1:0] CFG_LIVE_LIMIT = 2'd1;
    localparam logic [1:0] CFG_TOMB_LIMIT = 2'd2;

    localparam logic [47:0] EXP_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [63:0]  app;
        logic [63:0]  item;
        logic [255:0] digest;
    } t_key;

    typedef struct packed {
        t_key        key;
        logic [47:0] expiry;
    } t_tomb;
endpackage
`default_nettype wire

[rtl/core/dedup_registry_with_tombstones_unit.sv]
// each command reads tombstone slots below their limit, then live slots below theirs, one slot a cycle
// from memories with registered reads; done is a one-cycle strobe, no stall
// reset (synchronous, active low) clears valid bits, counts and statistics; limits get defaults
`timescale 1ns / 1ps
`default_nettype none
module dedup_registry_with_tombstones_unit import drt_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    output logic              o_busy,
    input  wire logic         i_command,
    input  wire logic [63:0]  i_app_id,
    input  wire logic [63:0]  i_item_id,
    input  wire logic [63:0]  i_digest_word_0,
    input  wire logic [63:0]  i_digest_word_1,
    input  wire logic [63:0]  i_digest_word_2,
    input  wire logic [63:0]  i_digest_word_3,
    input  wire logic [47:0]  i_now_ms,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data,
    output logic              o_done,
    output logic [1:0]        o_status,
    output logic [3:0]        o_slot,
    output logic [4:0]        o_live_total,
    output logic [4:0]        o_live_peak,
    output logic [6:0]        o_tomb_total,
    output logic [6:0]        o_tomb_peak,
    output logic [31:0]       o_dup_total,
    output logic [31:0]       o_full_total
);
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_TSCAN = 4'b0010,
        S_LSCAN = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    // entry storage, no reset: valid bits guard every read
    t_key  live_mem [LIVE_SLOTS];
    t_tomb tomb_mem [TOMB_SLOTS];
    t_key  r_lrd;
    t_tomb r_trd;

    t_state r_state;
    logic [31:0] r_ttl;
    logic [4:0]  r_live_limit;
    logic [6:0]  r_tomb_limit;

    logic [LIVE_SLOTS-1:0] r_lv;
    logic [TOMB_SLOTS-1:0] r_tv;

    // latched command
    logic        r_cmd;
    t_key        r_key;
    logic [47:0] r_now;
    logic [4:0]  r_nl;
    logic [6:0]  r_nt;

    // scan pipeline: address issued, entry processed in the next cycle
    logic [6:0] r_addr;
    logic [6:0] r_pidx;
    logic       r_pv;

    // scan results
    logic               r_dup;
    logic               r_lhit;      // free slot on register, match on retire
    logic [LIVE_IW-1:0] r_lidx;
    logic               r_thave;
    logic [TOMB_IW-1:0] r_tidx;

    logic [4:0]  r_live_cnt, r_live_hw;
    logic [6:0]  r_tomb_cnt, r_tomb_hw;
    logic [31:0] r_dup_cnt, r_full_cnt;

    logic        accept;
    logic        fin_reg_ok, fin_ret_ok, tomb_wr;
    logic [48:0] exp_sum;
    logic [47:0] exp_val;
    logic [4:0]  n_live_cnt;
    logic [6:0]  n_tomb_cnt;
    logic [4:0]  eff_live;
    logic [6:0]  eff_tomb;
    logic        is_fin;

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;
    assign is_fin      = (r_state == S_FIN);

    assign eff_live = (r_live_limit < 5'(LIVE_SLOTS)) ? r_live_limit : 5'(LIVE_SLOTS);
    assign eff_tomb = (r_tomb_limit < 7'(TOMB_SLOTS)) ? r_tomb_limit : 7'(TOMB_SLOTS);

    // final decisions for the command in flight
    assign fin_reg_ok = (r_cmd == CMD_REGISTER) && !r_dup && r_lhit;
    assign fin_ret_ok = (r_cmd == CMD_RETIRE) && r_lhit;
    assign tomb_wr    = fin_ret_ok && r_thave;

    // tombstone expiry, saturating at the 48-bit limit
    assign exp_sum = {1'b0, r_now} + {17'd0, r_ttl};
    assign exp_val = exp_sum[48] ? EXP_MAX : exp_sum[47:0];

    always_comb begin
        n_live_cnt = r_live_cnt;
        n_tomb_cnt = r_tomb_cnt;
        if (fin_reg_ok && r_live_cnt != 5'h1F) begin
            n_live_cnt = r_live_cnt + 5'd1;
        end else if (fin_ret_ok && r_live_cnt != 5'd0) begin
            n_live_cnt = r_live_cnt - 5'd1;
        end
        if (tomb_wr && r_tomb_cnt != 7'h7F) begin
            n_tomb_cnt = r_tomb_cnt + 7'd1;
        end
    end

    // live memory: registered read, write of a new entry at the end of a register
    always_ff @(posedge i_clk) begin
        if (is_fin && fin_reg_ok) begin
            live_mem[r_lidx] <= r_key;
        end
        r_lrd <= live_mem[r_addr[LIVE_IW-1:0]];
    end

    // tombstone memory: registered read, write of a tombstone at the end of a retire
    always_ff @(posedge i_clk) begin
        if (is_fin && tomb_wr) begin
            tomb_mem[r_tidx] <= '{key: r_key, expiry: exp_val};
        end
        r_trd <= tomb_mem[r_addr[TOMB_IW-1:0]];
    end

    // command latch, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_key <= '{app: i_app_id, item: i_item_id,
                       digest: {i_digest_word_3, i_digest_word_2,
                                i_digest_word_1, i_digest_word_0}};
            r_now <= i_now_ms;
            r_nl  <= eff_live;
            r_nt  <= eff_tomb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ttl        <= 32'd60000;
            r_live_limit <= 5'd16;
            r_tomb_limit <= 7'd64;
            r_lv         <= '0;
            r_tv         <= '0;
            r_addr       <= '0;
            r_pidx       <= '0;
            r_pv         <= 1'b0;
            r_dup        <= 1'b0;
            r_lhit       <= 1'b0;
            r_lidx       <= '0;
            r_thave      <= 1'b0;
            r_tidx       <= '0;
            r_live_cnt   <= '0;
            r_live_hw    <= '0;
            r_tomb_cnt   <= '0;
            r_tomb_hw    <= '0;
            r_dup_cnt    <= '0;
            r_full_cnt   <= '0;
            o_done       <= 1'b0;
            o_status     <= ST_OK;
            o_slot       <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_TTL:        r_ttl        <= i_cfg_data;
                    CFG_LIVE_LIMIT: r_live_limit <= i_cfg_data[4:0];
                    CFG_TOMB_LIMIT: r_tomb_limit <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_TSCAN;
                        r_addr  <= '0;
                        r_pv    <= 1'b0;
                        r_dup   <= 1'b0;
                        r_lhit  <= 1'b0;
                        r_thave <= 1'b0;
                    end
                end
                S_TSCAN: begin
                    if (r_addr < r_nt) begin
                        r_pv   <= 1'b1;
                        r_pidx <= r_addr;
                        r_addr <= r_addr + 7'd1;
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            r_state <= S_LSCAN;
                            r_addr  <= '0;
                        end
                    end
                    if (r_pv) begin
                        if (r_cmd == CMD_REGISTER) begin
                            // expire first, then match what survives
                            if (r_tv[r_pidx[TOMB_IW-1:0]]) begin
                                if (r_now >= r_trd.expiry) begin
                                    r_tv[r_pidx[TOMB_IW-1:0]] <= 1'b0;
                                    if (r_tomb_cnt != 7'd0) begin
                                        r_tomb_cnt <= r_tomb_cnt - 7'd1;
                                    end
                                end else if (r_trd.key == r_key) begin
                                    r_dup <= 1'b1;
                                end
                            end
                        end else if (!r_tv[r_pidx[TOMB_IW-1:0]] && !r_thave) begin
                            r_thave <= 1'b1;
                            r_tidx  <= r_pidx[TOMB_IW-1:0];
                        end
                    end
                end
                S_LSCAN: begin
                    if (r_addr < 7'(r_nl)) begin
                        r_pv   <= 1'b1;
                        r_pidx <= r_addr;
                        r_addr <= r_addr + 7'd1;
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            r_state <= S_FIN;
                        end
                    end
                    if (r_pv) begin
                        if (r_cmd == CMD_REGISTER) begin
                            if (!r_dup) begin
                                if (!r_lv[r_pidx[LIVE_IW-1:0]]) begin
                                    if (!r_lhit) begin
                                        r_lhit <= 1'b1;
                                        r_lidx <= r_pidx[LIVE_IW-1:0];
                                    end
                                end else if (r_lrd == r_key) begin
                                    r_dup <= 1'b1;
                                end
                            end
                        end else if (r_lv[r_pidx[LIVE_IW-1:0]] && !r_lhit
                                     && r_lrd == r_key) begin
                            // lowest matching slot
                            r_lhit <= 1'b1;
                            r_lidx <= r_pidx[LIVE_IW-1:0];
                        end
                    end
                end
                S_FIN: begin
                    r_state    <= S_IDLE;
                    o_done     <= 1'b1;
                    o_slot     <= '0;
                    r_live_cnt <= n_live_cnt;
                    r_tomb_cnt <= n_tomb_cnt;
                    if (n_live_cnt > r_live_hw) begin
                        r_live_hw <= n_live_cnt;
                    end
                    if (n_tomb_cnt > r_tomb_hw) begin
                        r_tomb_hw <= n_tomb_cnt;
                    end
                    if (r_cmd == CMD_REGISTER) begin
                        if (r_dup) begin
                            o_status <= ST_DUP;
                            if (r_dup_cnt != 32'hFFFF_FFFF) begin
                                r_dup_cnt <= r_dup_cnt + 32'd1;
                            end
                        end else if (!r_lhit) begin
                            o_status <= ST_FULL;
                            if (r_full_cnt != 32'hFFFF_FFFF) begin
                                r_full_cnt <= r_full_cnt + 32'd1;
                            end
                        end else begin
                            o_status      <= ST_OK;
                            o_slot        <= 4'(r_lidx);
                            r_lv[r_lidx]  <= 1'b1;
                        end
                    end else if (!r_lhit) begin
                        o_status <= ST_NOT_LIVE;
                    end else begin
                        o_status     <= ST_OK;
                        o_slot       <= 4'(r_lidx);
                        r_lv[r_lidx] <= 1'b0;
                        if (r_thave) begin
                            r_tv[r_tidx] <= 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // statistics are shown straight from their registers
    assign o_live_total = r_live_cnt;
    assign o_live_peak  = r_live_hw;
    assign o_tomb_total = r_tomb_cnt;
    assign o_tomb_peak  = r_tomb_hw;
    assign o_dup_total  = r_dup_cnt;
    assign o_full_total = r_full_cnt;
endmodule
`default_nettype wire

[rtl/core/drt_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "dedup_registry_with_tombstones_unit_assert.svh"
module drt_chk import drt_pkg::*; (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_start,
    input wire logic         o_busy,
    input wire logic         o_done,
    input wire logic [1:0]   o_status,
    input wire logic [3:0]   o_slot,
    input wire logic [4:0]   o_live_total,
    input wire logic [4:0]   o_live_peak,
    input wire logic [6:0]   o_tomb_total,
    input wire logic [6:0]   o_tomb_peak
);
    // a transfer makes the unit busy on the next cycle
    `DRT_ASSERT(a_start_busy, i_clk, i_rst_n, (i_start && !o_busy) |=> o_busy)
    // the result strobe comes once the unit has gone idle
    `DRT_ASSERT(a_done_idle, i_clk, i_rst_n, o_done |-> (!o_busy && $past(o_busy)))
    // a rejected command reports slot zero
    `DRT_ASSERT(a_slot_zero, i_clk, i_rst_n, (o_done && o_status != ST_OK) |-> (o_slot == 4'd0))
    // peaks never fall below the current counts
    `DRT_ASSERT(a_peaks, i_clk, i_rst_n,
        (o_live_peak >= o_live_total) && (o_tomb_peak >= o_tomb_total))
    // reset leaves the unit idle with no result strobe
    `DRT_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> (!o_done && !o_busy))
endmodule

bind dedup_registry_with_tombstones_unit drt_chk u_drt_chk (.*);
`default_nettype wire
